/* hdl/sn2_pkg.sv */
// Shared constants, gradient decode and helpers for the 2-D simplex noise block.
`default_nettype none
package sn2_pkg;

	// Default geometry
	localparam int TABLE_ENTRIES_DEF   = 256;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// Skew and unskew factors with 30 fraction bits
	localparam longint F2_Q30 = 64'd393016785;
	localparam longint G2_Q30 = 64'd226908346;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Gradient vector, each component -1, 0 or +1
	typedef struct packed {
		logic signed [1:0] gx;
		logic signed [1:0] gy;
	} grad_t;

	// Twelve gradient codes onto eight directions
	function automatic grad_t grad_of(input logic [3:0] g);
		grad_t r;
		r = '{gx: 2'sd0, gy: 2'sd0};
		case (g)
			4'd0: r = '{gx: 2'sd1, gy: 2'sd1};
			4'd1: r = '{gx: -2'sd1, gy: 2'sd1};
			4'd2: r = '{gx: 2'sd1, gy: -2'sd1};
			4'd3: r = '{gx: -2'sd1, gy: -2'sd1};
			4'd4, 4'd6: r = '{gx: 2'sd1, gy: 2'sd0};
			4'd5, 4'd7: r = '{gx: -2'sd1, gy: 2'sd0};
			4'd8, 4'd10: r = '{gx: 2'sd0, gy: 2'sd1};
			4'd9, 4'd11: r = '{gx: 2'sd0, gy: -2'sd1};
			default: r = '{gx: 2'sd0, gy: 2'sd0};
		endcase
		return r;
	endfunction

	// Byte mod 12 through a reciprocal multiply (exact for 0..255)
	function automatic logic [3:0] mod12(input logic [7:0] p);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [7:0]  r;
		prod = 16'(p) * 16'd171;
		q    = 5'(prod >> 11);
		r    = p - 8'(8'(q) * 8'd12);
		return 4'(r);
	endfunction

endpackage
`default_nettype wire

/* hdl/sn2_ram.sv */
// Permutation table copy: one write port, one registered read port.
`default_nettype none
module sn2_ram #(
	parameter int DEPTH = sn2_pkg::TABLE_ENTRIES_DEF,
	parameter int AW    = $clog2(sn2_pkg::TABLE_ENTRIES_DEF)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);
	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* hdl/sn2_wrap.sv */
// Two-stage reduction of an unsigned value modulo the table size.
`default_nettype none
module sn2_wrap #(
	parameter int N = sn2_pkg::TABLE_ENTRIES_DEF,
	parameter int W = 8
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [W-1:0]         v,
	output logic [$clog2(N)-1:0]      r
);
	localparam int     IDXW = $clog2(N);
	localparam int     RW   = ((W > IDXW) ? W : IDXW) + 1;
	localparam int     PW   = 2 * W;
	localparam longint M    = (longint'(1) << W) / N;

	logic [W-1:0]  v_s1;
	logic [W-1:0]  q_s1;
	logic [PW-1:0] prod_w;
	logic [RW-1:0] rem_w;

	// quotient estimate: floor(v / N) or one less
	assign prod_w = PW'(v) * PW'(M);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v;
			q_s1 <= W'(prod_w >> W);
		end
	end

	// remainder below 2N, one correction
	assign rem_w = RW'(v_s1) - RW'(RW'(q_s1) * RW'(N));

	always_ff @(posedge clk) begin
		if (en) begin
			r <= (rem_w >= RW'(N)) ? IDXW'(rem_w - RW'(N)) : IDXW'(rem_w);
		end
	end
endmodule
`default_nettype wire

/* hdl/sn2_corner.sv */
// Corner contribution (0.5 - r^2)^4 * dot(g, d), pipelined over six stages.
`default_nettype none
module sn2_corner #(
	parameter int F  = sn2_pkg::COORD_FRAC_BITS_DEF,
	parameter int DW = sn2_pkg::COORD_FRAC_BITS_DEF + 8
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [DW-1:0]     dx,
	input  wire logic signed [DW-1:0]     dy,
	input  wire logic [3:0]               gcode,
	output logic signed [DW+31-F:0]       term
);
	import sn2_pkg::*;

	localparam int SQW = 2 * DW;
	localparam int TTW = 2 * DW + 2;
	localparam int PRW = DW + 32;
	localparam int TMW = PRW - F;
	localparam int SHR = (2 * F >= 30) ? 2 * F - 30 : 0;
	localparam int SHL = (2 * F < 30) ? 30 - 2 * F : 0;
	localparam logic signed [TTW-1:0] HALF = TTW'(longint'(1) <<< (2 * F - 1));

	logic signed [SQW-1:0] dxx_s10, dyy_s10;
	logic signed [DW-1:0]  dx_s10, dy_s10, dx_s11, dy_s11, dx_s12, dy_s12, dx_s13, dy_s13;
	logic signed [TTW-1:0] tt_s11;
	logic                  neg_s12, neg_s13;
	logic [59:0]           t2f_s12, t4f_s13;
	logic [29:0]           t4_s14;
	logic signed [DW:0]    dot_s14;
	logic signed [PRW-1:0] prod_s15;
	logic [2*F-1:0]        ttu_w;
	logic [29:0]           t30_w;
	logic [29:0]           t2_w;
	grad_t                 g_w;
	logic signed [DW:0]    px_w, py_w;

	// 0.5 - r^2 moved to 30 fraction bits
	assign ttu_w = tt_s11[2*F-1:0];
	assign t30_w = 30'((64'(ttu_w) << SHL) >> SHR);
	assign t2_w  = t2f_s12[59:30];

	// gradient dot product
	always_comb begin
		g_w = grad_of(gcode);
		if (g_w.gx == 2'sd1) begin
			px_w = (DW+1)'(dx_s13);
		end else if (g_w.gx == -2'sd1) begin
			px_w = -(DW+1)'(dx_s13);
		end else begin
			px_w = '0;
		end
		if (g_w.gy == 2'sd1) begin
			py_w = (DW+1)'(dy_s13);
		end else if (g_w.gy == -2'sd1) begin
			py_w = -(DW+1)'(dy_s13);
		end else begin
			py_w = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squares
			dxx_s10 <= SQW'(dx) * SQW'(dx);
			dyy_s10 <= SQW'(dy) * SQW'(dy);
			dx_s10  <= dx;
			dy_s10  <= dy;
			// falloff
			tt_s11  <= HALF - TTW'(dxx_s10) - TTW'(dyy_s10);
			dx_s11  <= dx_s10;
			dy_s11  <= dy_s10;
			// square
			t2f_s12 <= 60'(t30_w) * 60'(t30_w);
			neg_s12 <= tt_s11 < 0;
			dx_s12  <= dx_s11;
			dy_s12  <= dy_s11;
			// fourth power
			t4f_s13 <= 60'(t2_w) * 60'(t2_w);
			neg_s13 <= neg_s12;
			dx_s13  <= dx_s12;
			dy_s13  <= dy_s12;
			// negative falloff contributes nothing
			t4_s14  <= neg_s13 ? '0 : t4f_s13[59:30];
			dot_s14 <= px_w + py_w;
			// weight times dot
			prod_s15 <= PRW'($signed({1'b0, t4_s14})) * PRW'(dot_s14);
		end
	end

	assign term = TMW'(prod_s15 >>> F);
endmodule
`default_nettype wire

/* hdl/simplex_noise_2d.sv */
// Top level of the 2-D simplex noise evaluator with loadable permutation table.
// One word per clock on the command channel while cmd_stall is low, loads and
// evaluations alike; an evaluation returns a noise word, a load returns nothing.
// Along the pipeline, the skew multiply, floor, unskew
// multiply, cell wrap, the first table lookup, the hash wrap, the second lookup
// and the corner falloff chain each take their own registered stages. The table is
// held in five copies, each with one read port; a load writes the two copies for
// the first lookup when it reaches that stage and the three for the second lookup
// when it reaches that one, so every evaluation sees the table exactly as left by
// the loads ahead of it. Table entries must be loaded before they are read; there
// is no clear after reset. A stall on the result side holds the whole pipeline.
`default_nettype none
module simplex_noise_2d #(
	parameter int TABLE_ENTRIES   = sn2_pkg::TABLE_ENTRIES_DEF,
	parameter int COORD_FRAC_BITS = sn2_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic               command,
	input  wire logic [7:0]         table_index,
	input  wire logic [7:0]         table_value,
	input  wire logic signed [31:0] x_coord,
	input  wire logic signed [31:0] y_coord,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic signed [15:0]      noise_value
);
	import sn2_pkg::*;

	localparam int F    = COORD_FRAC_BITS;
	localparam int IDXW = $clog2(TABLE_ENTRIES);
	localparam int SW   = 34;
	localparam int XW   = 35;
	localparam int IW   = XW - F;
	localparam int UW   = IW + 1;
	localparam int TPW  = IW + 30;
	localparam int TW   = 35;
	localparam int EW   = 40;
	localparam int DW   = F + 8;
	localparam int TMW  = DW + 32 - F;
	localparam int SMW  = TMW + 2;
	localparam int P7W  = SMW + 8;
	localparam int SUMW = ((IDXW > 8) ? IDXW : 8) + 2;
	localparam int NST  = 17;
	localparam longint OFF =
		((longint'(1) << (IW - 1)) + TABLE_ENTRIES - 1) / TABLE_ENTRIES * TABLE_ENTRIES;
	localparam longint G2F = (G2_Q30 + (longint'(1) << (29 - F))) >> (30 - F);
	localparam logic signed [29:0]  F2S    = 30'(F2_Q30);
	localparam logic signed [28:0]  G2S    = 29'(G2_Q30);
	localparam logic signed [DW-1:0] ONE_D = DW'(longint'(1) << F);
	localparam logic signed [DW-1:0] G2F_D = DW'(G2F);
	localparam logic signed [DW-1:0] G2F2_D = DW'(2 * G2F);
	localparam logic signed [7:0]   SCALE  = 8'sd70;

	// flow control
	logic adv;
	logic [NST:1] v_q;
	logic [NST:1] e_q;
	logic res_valid_q;
	logic signed [15:0] noise_q;

	assign adv       = !res_valid_q || !res_stall;
	assign cmd_stall = !adv;
	assign res_valid = res_valid_q;
	assign noise_value = noise_q;

	// pipeline payload
	logic signed [31:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5, x_s6;
	logic signed [31:0] y_s6;
	logic signed [32:0] sxy_s1;
	logic [7:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [7:0] val_s1, val_s2, val_s3, val_s4, val_s5, val_s6, val_s7, val_s8, val_s9;
	logic [7:0] val_s10, val_s11;
	logic signed [46:0] phi_s2;
	logic [44:0] plo_s2;
	logic signed [SW-1:0] s_s3;
	logic signed [XW-1:0] xs_s4, ys_s4;
	logic signed [IW-1:0] i_s5, j_s5, i_s6, j_s6;
	logic signed [IW:0]   ij_s5;
	logic [UW-1:0] ui_s5, uj_s5;
	logic signed [TPW-1:0] tprod_s6;
	logic signed [DW-1:0] x0_s7, y0_s7, x0_s8, y0_s8;
	logic i1_s8;
	logic [IDXW-1:0] ii_s8, widx_s8, widx_s9, widx_s10, widx_s11;
	logic [SUMW-1:0] suma_s9, sumb_s9, sumc_s9;
	logic signed [DW-1:0] d0x_s9, d0y_s9, d1x_s9, d1y_s9, d2x_s9, d2y_s9;
	logic [3:0] gc0_s13, gc1_s13, gc2_s13;
	logic signed [SMW-1:0] sum_s16;
	logic signed [P7W-1:0] sum70_s17;

	// combinational helpers
	logic signed [16:0]  hi_w;
	logic [15:0]         lo_w;
	logic signed [63:0]  prod_w;
	logic signed [IW-1:0] i_w, j_w;
	logic signed [TW-1:0] t_w;
	logic signed [EW-1:0] x0_w, y0_w;
	logic [IDXW-1:0] ii_w, jj_w, jj1_w, widx_w, ha_w, hb_w, hc_w;
	logic [7:0] pa0_w, pa1_w, g0raw_w, g1raw_w, g2raw_w;
	logic signed [TMW-1:0] term0_w, term1_w, term2_w;
	logic signed [P7W-1:0] rnd_w;
	logic we_a, we_b;

	assign hi_w   = $signed(sxy_s1[32:16]);
	assign lo_w   = sxy_s1[15:0];
	assign prod_w = (64'(phi_s2) <<< 16) + $signed(64'(plo_s2));
	assign i_w    = IW'(xs_s4 >>> F);
	assign j_w    = IW'(ys_s4 >>> F);
	assign t_w    = TW'(tprod_s6 >>> (30 - F));
	assign x0_w   = EW'(x_s6) - (EW'(i_s6) <<< F) + EW'(t_w);
	assign y0_w   = EW'(y_s6) - (EW'(j_s6) <<< F) + EW'(t_w);
	assign jj1_w  = (jj_w == IDXW'(TABLE_ENTRIES - 1)) ? '0 : jj_w + IDXW'(1);
	assign rnd_w  = (sum70_s17 + P7W'(32768)) >>> 16;
	assign we_a   = adv && v_q[7] && (e_q[7] == CMD_LOAD);
	assign we_b   = adv && v_q[11] && (e_q[11] == CMD_LOAD);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_q         <= {v_q[NST-1:1], cmd_valid};
			res_valid_q <= v_q[NST] && (e_q[NST] == CMD_EVAL);
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			e_q <= {e_q[NST-1:1], command};
			// s1: capture, x + y
			x_s1   <= x_coord;
			y_s1   <= y_coord;
			sxy_s1 <= 33'(x_coord) + 33'(y_coord);
			idx_s1 <= table_index;
			val_s1 <= table_value;
			// s2: skew partial products
			phi_s2 <= 47'(hi_w) * 47'(F2S);
			plo_s2 <= 45'(lo_w) * 45'(F2_Q30);
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			// s3: skew amount
			s_s3   <= SW'(prod_w >>> 30);
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
			// s4: skewed coordinates
			xs_s4  <= XW'(x_s3) + XW'(s_s3);
			ys_s4  <= XW'(y_s3) + XW'(s_s3);
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			idx_s4 <= idx_s3;
			val_s4 <= val_s3;
			// s5: cell, offset to non-negative for wrapping
			i_s5   <= i_w;
			j_s5   <= j_w;
			ij_s5  <= (IW+1)'(i_w) + (IW+1)'(j_w);
			ui_s5  <= UW'(i_w) + UW'(OFF);
			uj_s5  <= UW'(j_w) + UW'(OFF);
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			idx_s5 <= idx_s4;
			val_s5 <= val_s4;
			// s6: unskew product
			tprod_s6 <= TPW'(ij_s5) * TPW'(G2S);
			x_s6   <= x_s5;
			y_s6   <= y_s5;
			i_s6   <= i_s5;
			j_s6   <= j_s5;
			val_s6 <= val_s5;
			// s7: first corner offset
			x0_s7  <= DW'(x0_w);
			y0_s7  <= DW'(y0_w);
			val_s7 <= val_s6;
			// s8: corner order
			i1_s8   <= x0_s7 > y0_s7;
			x0_s8   <= x0_s7;
			y0_s8   <= y0_s7;
			ii_s8   <= ii_w;
			widx_s8 <= widx_w;
			val_s8  <= val_s7;
			// s9: hash sums and corner offsets
			suma_s9 <= SUMW'(ii_s8) + SUMW'(pa0_w);
			sumb_s9 <= SUMW'(ii_s8) + SUMW'(1) + SUMW'(pa1_w);
			sumc_s9 <= i1_s8 ? SUMW'(ii_s8) + SUMW'(1) + SUMW'(pa0_w)
			                 : SUMW'(ii_s8) + SUMW'(pa1_w);
			d0x_s9  <= x0_s8;
			d0y_s9  <= y0_s8;
			d1x_s9  <= x0_s8 - (i1_s8 ? ONE_D : '0) + G2F_D;
			d1y_s9  <= y0_s8 - (i1_s8 ? '0 : ONE_D) + G2F_D;
			d2x_s9  <= x0_s8 - ONE_D + G2F2_D;
			d2y_s9  <= y0_s8 - ONE_D + G2F2_D;
			widx_s9 <= widx_s8;
			val_s9  <= val_s8;
			// s10, s11: load word follows to the second lookup
			widx_s10 <= widx_s9;
			val_s10  <= val_s9;
			widx_s11 <= widx_s10;
			val_s11  <= val_s10;
			// s13: gradient codes
			gc0_s13 <= mod12(g0raw_w);
			gc1_s13 <= mod12(g1raw_w);
			gc2_s13 <= mod12(g2raw_w);
			// s16: sum of corners
			sum_s16 <= SMW'(term0_w) + SMW'(term1_w) + SMW'(term2_w);
			// s17: scale
			sum70_s17 <= P7W'(sum_s16) * P7W'(SCALE);
			// output: round and saturate
			if (rnd_w > P7W'(32767)) begin
				noise_q <= 16'sh7FFF;
			end else if (rnd_w < P7W'(-32768)) begin
				noise_q <= -16'sh8000;
			end else begin
				noise_q <= 16'(rnd_w);
			end
		end
	end

	// cell and load index wrapping (s5 -> s7)
	sn2_wrap #(.N(TABLE_ENTRIES), .W(UW)) u_wrap_i (
		.clk(clk), .en(adv), .v(ui_s5), .r(ii_w));
	sn2_wrap #(.N(TABLE_ENTRIES), .W(UW)) u_wrap_j (
		.clk(clk), .en(adv), .v(uj_s5), .r(jj_w));
	sn2_wrap #(.N(TABLE_ENTRIES), .W(8)) u_wrap_idx (
		.clk(clk), .en(adv), .v(idx_s5), .r(widx_w));

	// first lookup: perm[jj], perm[jj+1]
	sn2_ram #(.DEPTH(TABLE_ENTRIES), .AW(IDXW)) u_ram_a0 (
		.clk(clk), .we(we_a), .waddr(widx_w), .wdata(val_s7),
		.re(adv), .raddr(jj_w), .rdata(pa0_w));
	sn2_ram #(.DEPTH(TABLE_ENTRIES), .AW(IDXW)) u_ram_a1 (
		.clk(clk), .we(we_a), .waddr(widx_w), .wdata(val_s7),
		.re(adv), .raddr(jj1_w), .rdata(pa1_w));

	// hash wrapping (s9 -> s11)
	sn2_wrap #(.N(TABLE_ENTRIES), .W(SUMW)) u_wrap_ha (
		.clk(clk), .en(adv), .v(suma_s9), .r(ha_w));
	sn2_wrap #(.N(TABLE_ENTRIES), .W(SUMW)) u_wrap_hb (
		.clk(clk), .en(adv), .v(sumb_s9), .r(hb_w));
	sn2_wrap #(.N(TABLE_ENTRIES), .W(SUMW)) u_wrap_hc (
		.clk(clk), .en(adv), .v(sumc_s9), .r(hc_w));

	// second lookup: one copy per corner
	sn2_ram #(.DEPTH(TABLE_ENTRIES), .AW(IDXW)) u_ram_b0 (
		.clk(clk), .we(we_b), .waddr(widx_s11), .wdata(val_s11),
		.re(adv), .raddr(ha_w), .rdata(g0raw_w));
	sn2_ram #(.DEPTH(TABLE_ENTRIES), .AW(IDXW)) u_ram_b1 (
		.clk(clk), .we(we_b), .waddr(widx_s11), .wdata(val_s11),
		.re(adv), .raddr(hc_w), .rdata(g1raw_w));
	sn2_ram #(.DEPTH(TABLE_ENTRIES), .AW(IDXW)) u_ram_b2 (
		.clk(clk), .we(we_b), .waddr(widx_s11), .wdata(val_s11),
		.re(adv), .raddr(hb_w), .rdata(g2raw_w));

	// corner contributions (s9 -> s15)
	sn2_corner #(.F(F), .DW(DW)) u_corner0 (
		.clk(clk), .en(adv), .dx(d0x_s9), .dy(d0y_s9), .gcode(gc0_s13), .term(term0_w));
	sn2_corner #(.F(F), .DW(DW)) u_corner1 (
		.clk(clk), .en(adv), .dx(d1x_s9), .dy(d1y_s9), .gcode(gc1_s13), .term(term1_w));
	sn2_corner #(.F(F), .DW(DW)) u_corner2 (
		.clk(clk), .en(adv), .dx(d2x_s9), .dy(d2y_s9), .gcode(gc2_s13), .term(term2_w));

	// an empty output register never holds back the command side
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> !cmd_stall)
		else $error("command stalled with empty output register");

	// only evaluations leaving the last stage produce a result word
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_valid_q == $past(v_q[NST] && (e_q[NST] == CMD_EVAL))))
		else $error("result word does not match the last pipeline stage");

	// a held pipeline keeps its occupancy
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_q))
		else $error("pipeline moved while held");
endmodule
`default_nettype wire
